/* rtl/pet_pkg.sv */
// Shared types and constants for the periodic event timer bank.
package pet_pkg;

  localparam int MAX_SLOTS_DEF = 16;
  localparam int RESULT_CAP    = 16;
  localparam int PERIOD_W      = 32;
  localparam int SLOT_W        = 4;
  localparam int FCNT_W        = $clog2(RESULT_CAP + 1);

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_PAUSE  = 2'd2,
    KIND_RESUME = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_FIRED = 2'd0,
    ST_ADDED = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_WALK = 1'b1
  } seq_state_t;

  typedef struct packed {
    logic              vld;
    status_t           status;
    logic [SLOT_W-1:0] slot_id;
    logic              last;
  } res_t;

endpackage

/* rtl/pet_mem.sv */
// Slot table memory: one write port, one read port with registered read data.
module pet_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/pet_seq.sv */
// Command sequencer: slot allocation, run flag and the per-tick slot walk.
module pet_seq #(
  parameter int MAX_SLOTS = pet_pkg::MAX_SLOTS_DEF,
  parameter int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind,
  input  logic [pet_pkg::PERIOD_W-1:0] period,
  output logic                         mem_we,
  output logic [IDX_W-1:0]             mem_waddr,
  output logic [2*pet_pkg::PERIOD_W-1:0] mem_wdata,
  output logic                         mem_re,
  output logic [IDX_W-1:0]             mem_raddr,
  input  logic [2*pet_pkg::PERIOD_W-1:0] mem_rdata,
  output pet_pkg::res_t                res
);
  import pet_pkg::*;

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  seq_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   slots_used_r, slots_used_nxt;
  logic               running_r, running_nxt;
  logic [CNT_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic               v1_r, v1_nxt;
  logic [IDX_W-1:0]   v1_idx_r, v1_idx_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [FCNT_W-1:0]  fired_r, fired_nxt;

  logic [PERIOD_W-1:0] rd_period;
  logic [PERIOD_W-1:0] rd_count;
  logic [PERIOD_W-1:0] cnt_inc;
  logic                fire;
  kind_t               kind_in;

  assign rd_period = mem_rdata[2*PERIOD_W-1:PERIOD_W];
  assign rd_count  = mem_rdata[PERIOD_W-1:0];
  assign cnt_inc   = rd_count + PERIOD_W'(1);
  assign fire      = (cnt_inc >= rd_period);
  assign kind_in   = kind_t'(kind);
  assign busy      = (state_r != SEQ_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SEQ_IDLE;
      slots_used_r <= '0;
      running_r    <= 1'b0;
      rd_cnt_r     <= '0;
      v1_r         <= 1'b0;
      pend_v_r     <= 1'b0;
      fired_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      slots_used_r <= slots_used_nxt;
      running_r    <= running_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      v1_r         <= v1_nxt;
      pend_v_r     <= pend_v_nxt;
      fired_r      <= fired_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v1_idx_r   <= v1_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    slots_used_nxt = slots_used_r;
    running_nxt    = running_r;
    rd_cnt_nxt     = rd_cnt_r;
    v1_nxt         = 1'b0;
    v1_idx_nxt     = rd_cnt_r[IDX_W-1:0];
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    fired_nxt      = fired_r;
    mem_we         = 1'b0;
    mem_waddr      = v1_idx_r;
    mem_wdata      = {rd_period, cnt_inc};
    mem_re         = 1'b0;
    mem_raddr      = rd_cnt_r[IDX_W-1:0];
    res            = '0;

    case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          case (kind_in)
            KIND_TICK: begin
              if (running_r) begin
                state_nxt  = SEQ_WALK;
                rd_cnt_nxt = '0;
                fired_nxt  = '0;
                pend_v_nxt = 1'b0;
              end
            end
            KIND_ADD: begin
              res.vld  = 1'b1;
              res.last = 1'b1;
              if (slots_used_r < CNT_W'(MAX_SLOTS)) begin
                mem_we         = 1'b1;
                mem_waddr      = slots_used_r[IDX_W-1:0];
                mem_wdata      = {period, {PERIOD_W{1'b0}}};
                res.status     = ST_ADDED;
                res.slot_id    = SLOT_W'(slots_used_r);
                slots_used_nxt = slots_used_r + CNT_W'(1);
              end else begin
                res.status  = ST_FULL;
                res.slot_id = '0;
              end
            end
            KIND_PAUSE:  running_nxt = 1'b0;
            KIND_RESUME: running_nxt = 1'b1;
            default: ;
          endcase
        end
      end

      SEQ_WALK: begin
        // Reads run one slot ahead of the write-back; each slot is touched once.
        if (rd_cnt_r < slots_used_r) begin
          mem_re     = 1'b1;
          v1_nxt     = 1'b1;
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        end
        if (v1_r) begin
          mem_we    = 1'b1;
          mem_waddr = v1_idx_r;
          mem_wdata = {rd_period, fire ? {PERIOD_W{1'b0}} : cnt_inc};
          // A firing is held in the pending register until the next firing, so that the final one can carry last.
          if (fire && (fired_r < FCNT_W'(RESULT_CAP))) begin
            fired_nxt    = fired_r + FCNT_W'(1);
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = v1_idx_r;
            if (pend_v_r) begin
              res.vld     = 1'b1;
              res.status  = ST_FIRED;
              res.slot_id = SLOT_W'(pend_idx_r);
              res.last    = 1'b0;
            end
          end
        end
        if (!mem_re && !v1_r) begin
          state_nxt  = SEQ_IDLE;
          pend_v_nxt = 1'b0;
          if (pend_v_r) begin
            res.vld     = 1'b1;
            res.status  = ST_FIRED;
            res.slot_id = SLOT_W'(pend_idx_r);
            res.last    = 1'b1;
          end
        end
      end

      default: state_nxt = SEQ_IDLE;
    endcase
  end

  a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slots_used_r <= CNT_W'(MAX_SLOTS))
    else $error("slot count exceeds table depth");

  a_fired_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fired_r <= FCNT_W'(RESULT_CAP))
    else $error("firing count exceeds result cap");

  a_wb_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (state_r == SEQ_WALK))
    else $error("write-back stage active outside of a walk");

  a_idle_res_is_add: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && (state_r == SEQ_IDLE)) |-> (start && (kind_in == KIND_ADD)))
    else $error("idle result without an add command");

  a_walk_ends_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SEQ_WALK && state_nxt == SEQ_IDLE) |=> !pend_v_r && !v1_r)
    else $error("walk ended with a firing still pending");

endmodule

/* rtl/periodic_event_timer_bank_unit.sv */
// Top level of the periodic event timer bank: sequencer, slot memory, result register.
//
// Usage: a command word (in_kind, in_period) is taken on a rising edge where
// start is high and busy is low. Kinds: tick, add, pause, resume.
// An add is answered by one result word in the cycle right after acceptance:
// slot added with its id, or table full. busy stays low, so a new command may
// follow in the next cycle. Pause and resume give no result.
// A tick while running walks all used slots through the slot memory, one slot
// per cycle with registered read data, keeping busy high until the walk is done;
// up to 16 fired words come out, at most one per cycle, the final one marked by
// out_last in the cycle after the walk ends. A tick while paused gives no result.
// Each result word is shown for exactly one cycle with out_strobe; the
// receiver cannot stall the block.
// Reset (rst_n low, synchronous) empties the table and pauses the bank;
// the slot memory needs no clearing since only allocated slots are read.
module periodic_event_timer_bank_unit #(
  parameter int MAX_SLOTS = pet_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_kind,
  input  logic [pet_pkg::PERIOD_W-1:0] in_period,
  output logic                         out_strobe,
  output logic [1:0]                   out_status,
  output logic [pet_pkg::SLOT_W-1:0]   out_slot_id,
  output logic                         out_last
);
  import pet_pkg::*;

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int DW    = 2 * PERIOD_W;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [DW-1:0]    mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [DW-1:0]    mem_rdata;
  res_t             res;

  logic              strobe_r;
  logic [1:0]        status_r;
  logic [SLOT_W-1:0] slot_id_r;
  logic              last_r;

  pet_seq #(
    .MAX_SLOTS (MAX_SLOTS),
    .IDX_W     (IDX_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .kind      (in_kind),
    .period    (in_period),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res       (res)
  );

  pet_mem #(
    .DEPTH (MAX_SLOTS),
    .AW    (IDX_W),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= res.status;
    slot_id_r <= res.slot_id;
    last_r    <= res.last;
  end

  assign out_strobe  = strobe_r;
  assign out_status  = status_r;
  assign out_slot_id = slot_id_r;
  assign out_last    = last_r;

endmodule
